>>> hw/rtl/ax25_header_decoder_defines.svh
// Assertion macros for the header decoder.
`ifndef AX25_HEADER_DECODER_DEFINES_SVH
`define AX25_HEADER_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define AXD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define AXD_ASSERT(label, clk, rst_n, prop, msg)
`endif
`ifndef SYNTHESIS
`define AXD_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AXD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> hw/rtl/axd_pkg.sv
// ---------------------------------------------------------------------------
// axd_pkg
// Types and constants shared by the AX.25 header decoder modules.
// ---------------------------------------------------------------------------
package axd_pkg;

	localparam int MaxDigipeaters = 8;
	localparam int QDepth = 2;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_start;
		logic       frame_end;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [41:0] callsign;
		logic [3:0]  ssid;
		logic [3:0]  addr_flags;
		logic [7:0]  frame_type;
		logic [6:0]  send_seq;
		logic [6:0]  recv_seq;
		logic        poll_final;
		logic [1:0]  cmd_resp;
		logic [31:0] value;
		logic [7:0]  param_id;
		logic        last_of_frame;
	} out_word_t;

	localparam logic [3:0] KBad = 4'd0, KComp = 4'd1, KDest = 4'd2, KSrc = 4'd3,
		KDigi = 4'd4, KCtl = 4'd5, KPid = 4'd6, KSeg = 4'd7, KXidHead = 4'd8,
		KXidParam = 4'd9, KFrmr = 4'd10, KHandle = 4'd11, KEnd = 4'd12;

	localparam logic [7:0] TypeI = 8'h00, TypeUi = 8'h03, TypeXid = 8'hAF,
		TypeFrmr = 8'h87, TypeSabm = 8'h2F, TypeUa = 8'h63, PidSeg = 8'h08;

	// True when a 7-bit character is not a letter, digit or space.
	function automatic logic char_bad(input logic [6:0] c);
		logic ok;
		ok = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
			(c >= 7'h61 && c <= 7'h7A) || (c == 7'h20);
		return !ok;
	endfunction

endpackage

>>> hw/rtl/axd_front.sv
// ---------------------------------------------------------------------------
// axd_front
// Byte parser: tracks the frame phase and emits one decoded word per result.
// ---------------------------------------------------------------------------
module axd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_go,
	input  axd_pkg::in_word_t   in_w,
	output logic                res_valid,
	output axd_pkg::out_word_t  res_w
);

	typedef enum logic [4:0] {
		PhIdle, PhHead, PhComp, PhDest, PhSrc, PhDigi, PhCtl, PhCtl2, PhPid,
		PhSeg, PhPid2, PhInfo, PhXidHead, PhXidPi, PhXidPl, PhXidPv, PhFrmr, PhHandle
	} phase_t;

	phase_t      phase_q, ph_n, ph0;
	logic [3:0]  idx_q, idx_n, idx0;
	logic [41:0] call_q, call_n, call0;
	logic        dcmd_q, dcmd_n, dcmd0;
	logic [1:0]  cr_q, cr_n, cr0;
	logic [1:0]  mode_q, mode_n, mode0;
	logic [3:0]  digi_q, digi_n, digi0;
	logic [7:0]  cf_q, cf_n, cf0;
	logic [15:0] gl_q, gl_n, gl0, gl_m2;
	logic [7:0]  pl_q, pl_n, pl0;
	logic [31:0] acc_q, acc_n, acc0;
	logic [15:0] cnt_q, cnt_n, cnt0;
	logic [7:0]  pi_q, pi_n, pi0;

	logic [7:0] b;
	logic have, bad, shdr;
	axd_pkg::out_word_t r;
	logic [7:0] d2, d3, d4, d5, ct;
	logic [5:0] ch [6];
	logic [41:0] cs;
	logic [2:0] mflags;

	// Address result helper
	function automatic axd_pkg::out_word_t addr_w(input logic [3:0] k,
		input logic [41:0] c, input logic [7:0] sb, input logic [3:0] fl);
		axd_pkg::out_word_t w;
		logic inv;
		w = '0;
		inv = 1'b0;
		for (int i = 0; i < 6; i++) inv |= axd_pkg::char_bad(c[7*i +: 7]);
		w.kind = k;
		w.callsign = c;
		w.ssid = sb[4:1];
		w.addr_flags = fl | {2'b00, inv, 1'b0};
		return w;
	endfunction

	always_comb begin
		b = in_w.frame_byte;
		ph0 = phase_q; idx0 = idx_q; call0 = call_q; dcmd0 = dcmd_q; cr0 = cr_q;
		mode0 = mode_q; digi0 = digi_q; cf0 = cf_q; gl0 = gl_q; pl0 = pl_q;
		acc0 = acc_q; cnt0 = cnt_q; pi0 = pi_q;
		if (in_w.frame_start) begin
			ph0 = PhHead; idx0 = '0; call0 = '0; dcmd0 = 1'b0; cr0 = '0; mode0 = '0;
			digi0 = '0; cf0 = '0; gl0 = '0; pl0 = '0; acc0 = '0; cnt0 = '0; pi0 = '0;
		end
		ph_n = ph0; idx_n = idx0; call_n = call0; dcmd_n = dcmd0; cr_n = cr0;
		mode_n = mode0; digi_n = digi0; cf_n = cf0; gl_n = gl0; pl_n = pl0;
		acc_n = acc0; pi_n = pi0;
		cnt_n = cnt0;
		have = 1'b0; bad = 1'b0; shdr = 1'b0; r = '0;
		mflags = {mode0[1], mode0[0], 1'b0};
		gl_m2 = gl0 - 16'd2;
		d2 = call0[31:24]; d3 = call0[23:16]; d4 = call0[15:8]; d5 = call0[7:0];
		ch[0] = d2[7:2];
		ch[1] = {d2[1:0], d3[7:4]};
		ch[2] = {d3[3:0], d4[7:6]};
		ch[3] = d4[5:0];
		ch[4] = d5[7:2];
		ch[5] = {d5[1:0], b[7:4]};
		cs = '0;
		for (int i = 0; i < 6; i++) cs[7*(5-i) +: 7] = {1'b0, ch[i]} + 7'h20;
		ct = '0;
		if (ph0 >= PhSeg && ph0 != PhIdle && cnt0 != 16'hFFFF) cnt_n = cnt0 + 16'd1;

		case (ph0)
			PhHead: begin
				if (idx0 == 4'd0) begin
					acc_n = {24'd0, b}; idx_n = 4'd1;
				end else if (b[0]) begin
					acc_n = {18'd0, acc0[7:0], b[7:2]};
					cr_n = b[1] ? 2'd1 : 2'd2;
					call_n = '0; idx_n = 4'd2; ph_n = PhComp;
				end else begin
					call_n = {28'd0, acc0[7:1], b[7:1]}; idx_n = 4'd2; ph_n = PhDest;
				end
			end
			PhComp: begin
				if (idx0 < 4'd6) begin
					call_n = {call0[33:0], b}; idx_n = idx0 + 4'd1;
				end else begin
					r.kind = axd_pkg::KComp; r.callsign = cs; r.ssid = b[3:0];
					r.cmd_resp = cr0; r.value = {18'd0, acc0[13:0]};
					have = 1'b1; mode_n = '0; shdr = 1'b1; ph_n = PhCtl;
				end
			end
			PhDest, PhSrc, PhDigi: begin
				if (idx0 < 4'd6) begin
					call_n = {call0[34:0], b[7:1]}; idx_n = idx0 + 4'd1;
				end else begin
					idx_n = '0; call_n = '0;
					if (ph0 == PhDest) begin
						dcmd_n = b[7];
						r = addr_w(axd_pkg::KDest, call0, b, 4'd0);
						have = 1'b1; ph_n = PhSrc;
					end else if (ph0 == PhSrc) begin
						mode_n = {~b[5], ~b[6]};
						cr_n = (dcmd0 && !b[7]) ? 2'd1 : ((b[7] && !dcmd0) ? 2'd2 : 2'd0);
						r = addr_w(axd_pkg::KSrc, call0, b, {~b[5], ~b[6], 2'b00});
						r.cmd_resp = cr_n; have = 1'b1;
						if (b[0]) begin
							ph_n = PhCtl; shdr = 1'b1;
						end else ph_n = PhDigi;
					end else if (digi0 >= 4'(axd_pkg::MaxDigipeaters)) begin
						bad = 1'b1;
					end else begin
						digi_n = digi0 + 4'd1;
						r = addr_w(axd_pkg::KDigi, call0, b, {mflags, b[7]});
						r.cmd_resp = cr0; have = 1'b1;
						if (b[0]) ph_n = PhCtl;
					end
				end
			end
			PhCtl: begin
				have = 1'b1; r.kind = axd_pkg::KCtl; r.cmd_resp = cr0; r.poll_final = b[4];
				if (mode0[0] && b[1:0] != 2'b11) begin
					have = 1'b0; r = '0; cf_n = b; ph_n = PhCtl2;
				end else if (mode0[0] || b[1:0] == 2'b11) begin
					ct = b & 8'hEF;
				end else if (!b[0]) begin
					r.send_seq = {4'd0, b[3:1]}; r.recv_seq = {4'd0, b[7:5]};
				end else begin
					ct = {4'd0, b[3:0]}; r.recv_seq = {4'd0, b[7:5]};
				end
			end
			PhCtl2: begin
				have = 1'b1; r.kind = axd_pkg::KCtl; r.cmd_resp = cr0; r.poll_final = b[0];
				r.recv_seq = b[7:1];
				if (!cf0[0]) r.send_seq = cf0[7:1];
				else ct = cf0;
			end
			PhPid, PhPid2: begin
				r.kind = axd_pkg::KPid; r.value = {24'd0, b}; have = 1'b1;
				ph_n = (ph0 == PhPid && b == axd_pkg::PidSeg) ? PhSeg : PhInfo;
			end
			PhSeg: begin
				r.kind = axd_pkg::KSeg; r.value = {25'd0, b[6:0]}; r.param_id = {7'd0, b[7]};
				have = 1'b1; ph_n = b[7] ? PhPid2 : PhInfo;
			end
			PhXidHead: begin
				acc_n = {acc0[23:0], b}; idx_n = idx0 + 4'd1;
				if (idx_n >= 4'd4) begin
					r.kind = axd_pkg::KXidHead; r.value = acc_n; have = 1'b1;
					gl_n = acc_n[15:0];
					ph_n = (acc_n[15:0] >= 16'd2) ? PhXidPi : PhInfo;
				end
			end
			PhXidPi: begin
				pi_n = b; ph_n = PhXidPl;
			end
			PhXidPl: begin
				gl_n = gl_m2;
				if ({8'd0, b} > gl_m2) ph_n = PhInfo;
				else begin
					gl_n = gl_m2 - {8'd0, b}; pl_n = b; acc_n = '0;
					if (b == 8'd0) begin
						r.kind = axd_pkg::KXidParam; r.param_id = pi0; have = 1'b1;
						ph_n = (gl_n >= 16'd2) ? PhXidPi : PhInfo;
					end else ph_n = PhXidPv;
				end
			end
			PhXidPv: begin
				acc_n = {acc0[23:0], b}; pl_n = pl0 - 8'd1;
				if (pl_n == 8'd0) begin
					r.kind = axd_pkg::KXidParam; r.param_id = pi0; r.value = acc_n;
					have = 1'b1; ph_n = (gl0 >= 16'd2) ? PhXidPi : PhInfo;
				end
			end
			PhFrmr: begin
				if (idx0 == 4'd0) begin
					cf_n = b; idx_n = 4'd1;
				end else if (idx0 == 4'd1) begin
					acc_n = {24'd0, b}; idx_n = 4'd2;
				end else begin
					r.kind = axd_pkg::KFrmr; r.frame_type = cf0;
					r.recv_seq = {4'd0, acc0[7:5]}; r.send_seq = {4'd0, acc0[3:1]};
					r.param_id = {4'd0, b[3:0]}; have = 1'b1; ph_n = PhInfo;
				end
			end
			PhHandle: begin
				if (idx0 == 4'd0) begin
					acc_n = {24'd0, b}; idx_n = 4'd1;
				end else begin
					r.kind = axd_pkg::KHandle; r.value = {16'd0, acc0[7:0], b};
					have = 1'b1; ph_n = PhInfo;
				end
			end
			default: ;
		endcase

		// Leave control: pick the next phase by frame type
		if (r.kind == axd_pkg::KCtl && have) begin
			r.frame_type = ct; idx_n = '0; acc_n = '0;
			if (ct == axd_pkg::TypeI || ct == axd_pkg::TypeUi) ph_n = PhPid;
			else if (ct == axd_pkg::TypeXid) ph_n = PhXidHead;
			else if (ct == axd_pkg::TypeFrmr) ph_n = PhFrmr;
			else if (ct == axd_pkg::TypeSabm || ct == axd_pkg::TypeUa) ph_n = PhHandle;
			else ph_n = PhInfo;
		end

		res_valid = 1'b0; res_w = r;
		if (ph0 != PhIdle) begin
			if (bad || (in_w.frame_end && (shdr || ph_n == PhHead || ph_n == PhComp ||
				ph_n == PhDest || ph_n == PhSrc || ph_n == PhDigi || ph_n == PhCtl2))) begin
				res_w = '0; res_w.last_of_frame = 1'b1; res_valid = 1'b1; ph_n = PhIdle;
			end else if (in_w.frame_end) begin
				if (!have) begin
					res_w = '0; res_w.kind = axd_pkg::KEnd; res_w.value = {16'd0, cnt_n};
				end
				res_w.last_of_frame = 1'b1; res_valid = 1'b1; ph_n = PhIdle;
			end else res_valid = have;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle; idx_q <= '0; call_q <= '0; dcmd_q <= 1'b0; cr_q <= '0;
			mode_q <= '0; digi_q <= '0; cf_q <= '0; gl_q <= '0; pl_q <= '0;
			acc_q <= '0; cnt_q <= '0; pi_q <= '0;
		end else if (in_go) begin
			phase_q <= ph_n; idx_q <= idx_n; call_q <= call_n; dcmd_q <= dcmd_n;
			cr_q <= cr_n; mode_q <= mode_n; digi_q <= digi_n; cf_q <= cf_n;
			gl_q <= gl_n; pl_q <= pl_n; acc_q <= acc_n; cnt_q <= cnt_n; pi_q <= pi_n;
		end
	end

endmodule

>>> hw/rtl/axd_queue.sv
// ---------------------------------------------------------------------------
// axd_queue
// Two-entry result queue between the parser and the output port.
// ---------------------------------------------------------------------------
module axd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  axd_pkg::out_word_t  push_w,
	output logic                full,
	output logic                pop_valid,
	input  logic                pop_stall,
	output axd_pkg::out_word_t  pop_w
);

	axd_pkg::out_word_t mem_q [axd_pkg::QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full = (cnt_q == 2'(axd_pkg::QDepth));
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_w = mem_q[rp_q];
	assign pop = pop_valid && !pop_stall;

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_w;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/ax25_header_decoder.sv
// A result is pushed into the result queue as its byte is accepted, and out_valid is driven from that queue.
// Throughput: one byte per cycle while in_stall is low; the parser updates its phase state on each accepted byte.
// Stall on the input rises only while the two-word result queue is full.
// Reset (arst_n low) idles the parser and empties the queue.
// ---------------------------------------------------------------------------
// ax25_header_decoder
// AX.25 frame header decoder: parser front end feeding a result queue.
// ---------------------------------------------------------------------------
`include "ax25_header_decoder_defines.svh"
module ax25_header_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  axd_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output axd_pkg::out_word_t  out_data
);

	logic in_go, res_valid, full;
	axd_pkg::out_word_t res_w;

	assign in_stall = full;
	assign in_go = in_valid && !full;

	axd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .in_w(in_data),
		.res_valid(res_valid), .res_w(res_w)
	);

	axd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(in_go && res_valid), .push_w(res_w),
		.full(full), .pop_valid(out_valid), .pop_stall(out_stall), .pop_w(out_data)
	);

	`AXD_ASSERT(a_bad_closes, clk, arst_n, (out_valid && out_data.kind == axd_pkg::KBad) |-> out_data.last_of_frame, "bad word must close frame")
	`AXD_ASSERT(a_end_closes, clk, arst_n, (out_valid && out_data.kind == axd_pkg::KEnd) |-> out_data.last_of_frame, "end word must close frame")
	`AXD_ASSERT(a_push_room, clk, arst_n, (in_go && res_valid) |-> !full, "push into full queue")

endmodule
